// File: hdl/crfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting resource FIFO queue package
// Shared item types, status and action codes and register indexes.
// ----------------------------------------------------------------------------
package crfq_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned ID_W   = 16;

  localparam logic       ACTION_SEIZE   = 1'b0;
  localparam logic       ACTION_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_SERVED   = 2'd0;
  localparam logic [1:0] STATUS_ENQUEUED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;

  localparam logic       REG_SERVER_CAP = 1'b0;
  localparam logic       REG_QUEUE_CAP  = 1'b1;

  localparam logic [UNIT_W-1:0] SERVER_CAP_RESET = 16'd1;
  localparam logic [UNIT_W-1:0] QUEUE_CAP_RESET  = 16'd0;
  localparam logic [UNIT_W-1:0] UNITS_MAX        = 16'hFFFF;

  typedef struct packed {
    logic              action;
    logic [ID_W-1:0]   requester_id;
    logic [UNIT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              woken_valid;
    logic [ID_W-1:0]   woken_id;
    logic [UNIT_W-1:0] woken_amount;
    logic [UNIT_W-1:0] busy_units;
    logic [UNIT_W-1:0] waiting_units;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [UNIT_W-1:0] amount;
  } wait_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

endpackage

// File: hdl/counting_resource_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting resource FIFO queue
// Counting semaphore that serves, queues or rejects seize requests and
// releases units, waking the oldest waiter, if there is one, on every release.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while results are not stalled and
// returns exactly one result for each, offered from the result register after
// the input register: the request is decided there against the server and
// queue counts left by the one before, and the wait queue head is read from a
// RAM prefetched on the head pointer, so a release can pop it in that same
// cycle. A stalled result holds the request in the input register, and the
// input stalls while both registers are full and the result stalls. Up to
// WAIT_DEPTH waiters can be held. The user sets capacities through the
// register port while no request is in flight; the block does not enforce it.
module counting_resource_fifo_queue #(
  parameter int unsigned WAIT_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  crfq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output crfq_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned UW = crfq_pkg::UNIT_W;

  logic [UW-1:0]          server_cap_r, queue_cap_r;
  logic [UW-1:0]          server_units_r, server_units_nxt;
  logic [UW-1:0]          queued_units_r, queued_units_nxt;
  logic                   in_vld_r, in_vld_nxt;
  crfq_pkg::in_item_t     in_item_r;
  logic                   out_vld_r, out_vld_nxt;
  crfq_pkg::out_item_t    out_item_r, out_item_nxt;
  logic                   advance, fire, accept;
  logic                   cfg_write;
  logic                   reg_index;
  crfq_pkg::fifo_cmd_t    fifo_cmd;
  crfq_pkg::fifo_status_t fifo_status;
  crfq_pkg::wait_entry_t  head_data, push_data;
  logic [UW:0]            srv_sum, que_sum, wake_sum;
  logic [UW-1:0]          srv_left;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_cap_r <= crfq_pkg::SERVER_CAP_RESET;
      queue_cap_r  <= crfq_pkg::QUEUE_CAP_RESET;
    end else if (cfg_write) begin
      unique case (reg_index)
        crfq_pkg::REG_SERVER_CAP: server_cap_r <= pwdata[UW-1:0];
        crfq_pkg::REG_QUEUE_CAP:  queue_cap_r  <= pwdata[UW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      crfq_pkg::REG_SERVER_CAP: prdata = {16'd0, server_cap_r};
      crfq_pkg::REG_QUEUE_CAP:  prdata = {16'd0, queue_cap_r};
      default:                  prdata = '0;
    endcase
  end

  // Handshake between the input register and the result register.
  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Request decision.
  assign push_data.id     = in_item_r.requester_id;
  assign push_data.amount = in_item_r.amount;

  always_comb begin
    srv_sum  = {1'b0, server_units_r} + {1'b0, in_item_r.amount};
    que_sum  = {1'b0, queued_units_r} + {1'b0, in_item_r.amount};
    srv_left = (server_units_r > in_item_r.amount) ?
               server_units_r - in_item_r.amount : '0;
    wake_sum = {1'b0, srv_left} + {1'b0, head_data.amount};

    server_units_nxt = server_units_r;
    queued_units_nxt = queued_units_r;
    fifo_cmd         = '0;
    out_item_nxt     = '0;

    if (in_item_r.action == crfq_pkg::ACTION_SEIZE) begin
      if (srv_sum <= {1'b0, server_cap_r}) begin
        server_units_nxt    = srv_sum[UW-1:0];
        out_item_nxt.status = crfq_pkg::STATUS_SERVED;
      end else if (que_sum <= {1'b0, queue_cap_r} && !fifo_status.full) begin
        queued_units_nxt    = que_sum[UW-1:0];
        fifo_cmd.push       = fire;
        out_item_nxt.status = crfq_pkg::STATUS_ENQUEUED;
      end else begin
        out_item_nxt.status = crfq_pkg::STATUS_REJECTED;
      end
    end else begin
      server_units_nxt    = srv_left;
      out_item_nxt.status = crfq_pkg::STATUS_SERVED;
      if (!fifo_status.empty) begin
        fifo_cmd.pop              = fire;
        out_item_nxt.woken_valid  = 1'b1;
        out_item_nxt.woken_id     = head_data.id;
        out_item_nxt.woken_amount = head_data.amount;
        queued_units_nxt = (queued_units_r > head_data.amount) ?
                           queued_units_r - head_data.amount : '0;
        server_units_nxt = wake_sum[UW] ? crfq_pkg::UNITS_MAX : wake_sum[UW-1:0];
      end
    end

    out_item_nxt.busy_units    = server_units_nxt;
    out_item_nxt.waiting_units = queued_units_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      server_units_r <= '0;
      queued_units_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        server_units_r <= server_units_nxt;
        queued_units_r <= queued_units_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  crfq_wait_fifo #(
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_wait_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fifo_cmd),
    .push_data (push_data),
    .head_data (head_data),
    .status    (fifo_status)
  );

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// File: hdl/crfq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/crfq_wait_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wait queue FIFO
// Holds waiting (id, amount) pairs in a RAM and presents the head entry in
// the same cycle that it may be popped.
// ----------------------------------------------------------------------------
module crfq_wait_fifo #(
  parameter int unsigned WAIT_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  crfq_pkg::fifo_cmd_t   cmd,
  input  crfq_pkg::wait_entry_t push_data,
  output crfq_pkg::wait_entry_t head_data,
  output crfq_pkg::fifo_status_t status
);

  localparam int unsigned AW = $clog2(WAIT_DEPTH);
  localparam int unsigned CW = $clog2(WAIT_DEPTH + 1);

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  byp_r, byp_nxt;
  crfq_pkg::wait_entry_t byp_data_r;
  crfq_pkg::wait_entry_t rd_data;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // The read address follows the head pointer of the next cycle, so the
  // read data shows the current head entry, or the pushed entry via a bypass.
  always_comb begin
    head_nxt  = cmd.pop ? next_slot(head_r) : head_r;
    tail_nxt  = cmd.push ? next_slot(tail_r) : tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end
    byp_nxt = cmd.push && (tail_r == head_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      byp_r   <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= push_data;
  end

  crfq_ram #(
    .WIDTH ($bits(crfq_pkg::wait_entry_t)),
    .DEPTH (WAIT_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail_r),
    .wr_data (push_data),
    .rd_addr (head_nxt),
    .rd_data (rd_data)
  );

  assign head_data    = byp_r ? byp_data_r : rd_data;
  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(WAIT_DEPTH));

endmodule

// File: hdl/crfq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting resource FIFO queue checker
// Port level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module crfq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input crfq_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("Stalled result transfer changed or dropped.");

  a_wake_only_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != crfq_pkg::STATUS_SERVED |-> !out_item.woken_valid)
    else $error("Enqueued or rejected seize reported a woken waiter.");

  a_no_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.woken_valid |->
      out_item.woken_id == '0 && out_item.woken_amount == '0)
    else $error("Woken fields are not zero without a wake.");

endmodule

bind counting_resource_fifo_queue crfq_checker u_crfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
